@@ src/rhsv_pkg.sv @@
// Shared types for the RGB to HSV converter.
// No dependencies; used by rhsv_front, rgb_to_hsv_converter_top and rhsv_stream_checker.
`default_nettype none

package rhsv_pkg;

    // Which component holds the maximum; red wins ties, then green.
    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } t_sector;

endpackage

`default_nettype wire

@@ src/rhsv_front.sv @@
// Max/min search and hue sector select for one pixel (combinational).
// Depends on rhsv_pkg (t_sector).
`default_nettype none

module rhsv_front #(
    parameter int COMPONENT_BITS = 8
) (
    input  wire logic [COMPONENT_BITS-1:0] i_red,
    input  wire logic [COMPONENT_BITS-1:0] i_green,
    input  wire logic [COMPONENT_BITS-1:0] i_blue,
    output logic      [COMPONENT_BITS-1:0] o_max,
    output logic      [COMPONENT_BITS-1:0] o_min,
    output rhsv_pkg::t_sector              o_sector,
    output logic      [COMPONENT_BITS:0]   o_diff   // two's complement
);

    logic [COMPONENT_BITS:0] w_r;
    logic [COMPONENT_BITS:0] w_g;
    logic [COMPONENT_BITS:0] w_b;

    assign w_r = {1'b0, i_red};
    assign w_g = {1'b0, i_green};
    assign w_b = {1'b0, i_blue};

    always_comb begin
        if (i_red >= i_green && i_red >= i_blue) begin
            o_sector = rhsv_pkg::SECT_RED;
            o_max    = i_red;
            o_diff   = w_g - w_b;
        end else if (i_green >= i_blue) begin
            o_sector = rhsv_pkg::SECT_GREEN;
            o_max    = i_green;
            o_diff   = w_b - w_r;
        end else begin
            o_sector = rhsv_pkg::SECT_BLUE;
            o_max    = i_blue;
            o_diff   = w_r - w_g;
        end

        o_min = i_red;
        if (i_green < o_min) begin
            o_min = i_green;
        end
        if (i_blue < o_min) begin
            o_min = i_blue;
        end
    end

endmodule

`default_nettype wire

@@ src/rhsv_div_step.sv @@
// One restoring division step: optional shift, compare, conditional subtract.
// No dependencies.
`default_nettype none

module rhsv_div_step #(
    parameter int DW    = 8,
    parameter bit SHIFT = 1'b1
) (
    input  wire logic [DW-1:0] i_rem,     // never above i_div
    input  wire logic [DW-1:0] i_div,
    output logic      [DW-1:0] o_rem,
    output logic               o_bit
);

    logic [DW:0] w_trial;
    logic [DW:0] w_diff;

    assign w_trial = SHIFT ? {i_rem, 1'b0} : {1'b0, i_rem};
    assign w_diff  = w_trial - {1'b0, i_div};
    assign o_bit   = (w_trial >= {1'b0, i_div});
    assign o_rem   = o_bit ? w_diff[DW-1:0] : w_trial[DW-1:0];

endmodule

`default_nettype wire

@@ src/rgb_to_hsv_converter_top.sv @@
// RGB to HSV pixel converter, top level: stream ports and the stage pipeline.
// Depends on rhsv_pkg, rhsv_front and rhsv_div_step.
//
// Usage
//   Input stream (s_axis): one pixel per transfer, tdata = {blue, green, red},
//   red in the lowest bits, zero padded to whole bytes.
//   Output stream (m_axis): one result per pixel, tdata = {brightness,
//   saturation, hue_turn}, hue in the lowest bits, zero padded to bytes.
//   Hue is a fraction of a turn and saturation a fraction with
//   FRACTION_BITS fraction bits, both truncated; gray pixels give hue 0.
// Pipeline
//   One pixel enters per clock unless every stage is full and m_axis holds
//   off. Stage 0 finds max/min and the sector, stage 1 forms delta and the
//   hue numerator, then FRACTION_BITS + 1 stages run one restoring
//   division step each for saturation, all but the first also one for
//   hue, side by side; the last of them drives m_axis.
// Reset and stalls
//   Synchronous active-low reset empties the pipeline (all valid bits low).
//   Each stage holds its item while the next stage is full and stalled, so
//   empty stages keep filling while m_axis is held off; s_axis tready drops
//   only once every stage holds a pixel. Nothing is dropped or repeated.
`default_nettype none

module rgb_to_hsv_converter_top #(
    parameter int COMPONENT_BITS = 8,
    parameter int FRACTION_BITS  = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // {blue, green, red}, red at bit 0
    input  wire logic [((3*COMPONENT_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    input  wire logic               i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // {brightness, saturation, hue_turn}, hue_turn at bit 0
    output logic [((2*FRACTION_BITS+1+COMPONENT_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    output logic                    o_m_axis_tvalid,
    input  wire logic               i_m_axis_tready
);

    localparam int C      = COMPONENT_BITS;
    localparam int F      = FRACTION_BITS;
    localparam int OUT_W  = ((2*F+1+C+7)/8)*8;
    localparam int PAY_W  = 2*F + 1 + C;
    localparam int NSTAGE = F + 3;      // front, numerator, F+1 divide steps
    localparam int HW     = C + 3;      // hue remainder / 6*delta width

    // ---------------- flow control: per-stage valid, rippled ready --------
    logic [NSTAGE-1:0] r_valid;
    logic [NSTAGE:0]   w_rdy;

    assign w_rdy[NSTAGE] = i_m_axis_tready;

    genvar k;
    generate
        for (k = 0; k < NSTAGE; k++) begin : g_flow
            assign w_rdy[k] = !r_valid[k] || w_rdy[k+1];

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else if (w_rdy[k]) begin
                    r_valid[k] <= (k == 0) ? i_s_axis_tvalid : r_valid[(k == 0) ? 0 : k-1];
                end
            end
        end
    endgenerate

    assign o_s_axis_tready = w_rdy[0];

    // ---------------- stage 0: max, min, sector ---------------------------
    logic [C-1:0]      n0_max;
    logic [C-1:0]      n0_min;
    rhsv_pkg::t_sector n0_sector;
    logic [C:0]        n0_diff;

    rhsv_front #(.COMPONENT_BITS(C)) u_front (
        .i_red    (i_s_axis_tdata[C-1:0]),
        .i_green  (i_s_axis_tdata[2*C-1:C]),
        .i_blue   (i_s_axis_tdata[3*C-1:2*C]),
        .o_max    (n0_max),
        .o_min    (n0_min),
        .o_sector (n0_sector),
        .o_diff   (n0_diff)
    );

    logic [C-1:0]      r0_max;
    logic [C-1:0]      r0_min;
    rhsv_pkg::t_sector r0_sector;
    logic [C:0]        r0_diff;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r0_max    <= n0_max;
            r0_min    <= n0_min;
            r0_sector <= n0_sector;
            r0_diff   <= n0_diff;
        end
    end

    // ---------------- stage 1: delta, hue numerator, 6*delta --------------
    logic [C-1:0]   n1_delta;
    logic [HW-1:0]  n1_d6;
    logic [C+3:0]   n1_base;
    logic [C+3:0]   n1_num_raw;
    logic [C+3:0]   n1_num_wrap;

    always_comb begin
        n1_delta = r0_max - r0_min;
        n1_d6    = {1'b0, n1_delta, 2'b00} + {2'b00, n1_delta, 1'b0};
        unique case (r0_sector)
            rhsv_pkg::SECT_RED:   n1_base = '0;
            rhsv_pkg::SECT_GREEN: n1_base = {3'b000, n1_delta, 1'b0};
            rhsv_pkg::SECT_BLUE:  n1_base = {2'b00, n1_delta, 2'b00};
            default:              n1_base = '0;
        endcase
        n1_num_raw  = n1_base + {{3{r0_diff[C]}}, r0_diff};
        // negative hue wraps by one turn
        n1_num_wrap = n1_num_raw[C+3] ? (n1_num_raw + {1'b0, n1_d6}) : n1_num_raw;
    end

    logic [C-1:0]  r1_max;
    logic [C-1:0]  r1_delta;
    logic [HW-1:0] r1_d6;
    logic [HW-1:0] r1_num;
    logic          r1_gray;

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r1_max   <= r0_max;
            r1_delta <= n1_delta;
            r1_d6    <= n1_d6;
            r1_num   <= n1_num_wrap[HW-1:0];
            r1_gray  <= (n1_delta == '0);
        end
    end

    // ---------------- stages 2 .. F+2: restoring division -----------------
    // Saturation: delta * 2^F / max, F+1 quotient bits, first step unshifted.
    // Hue: num * 2^F / (6*delta), F quotient bits, steps 1 .. F.
    logic [C-1:0]  r_max  [0:F];
    logic [C-1:0]  r_srem [0:F];
    logic [F:0]    r_sq   [0:F];
    logic [HW-1:0] r_d6   [0:F];
    logic [HW-1:0] r_hrem [0:F];
    logic [F-1:0]  r_hq   [0:F];
    logic          r_gray [0:F];

    genvar j;
    generate
        for (j = 0; j <= F; j++) begin : g_div
            logic [C-1:0]  n_srem;
            logic          n_sbit;
            logic [F:0]    n_sq;
            logic [HW-1:0] n_hrem;
            logic [F-1:0]  n_hq;

            if (j == 0) begin : g_first
                rhsv_div_step #(.DW(C), .SHIFT(1'b0)) u_sat (
                    .i_rem (r1_delta),
                    .i_div (r1_max),
                    .o_rem (n_srem),
                    .o_bit (n_sbit)
                );
                assign n_sq   = {{F{1'b0}}, n_sbit};
                assign n_hrem = r1_num;
                assign n_hq   = '0;

                always_ff @(posedge i_clk) begin
                    if (w_rdy[2]) begin
                        r_max[0]  <= r1_max;
                        r_d6[0]   <= r1_d6;
                        r_gray[0] <= r1_gray;
                    end
                end
            end else begin : g_next
                logic n_hbit;

                rhsv_div_step #(.DW(C), .SHIFT(1'b1)) u_sat (
                    .i_rem (r_srem[j-1]),
                    .i_div (r_max[j-1]),
                    .o_rem (n_srem),
                    .o_bit (n_sbit)
                );
                rhsv_div_step #(.DW(HW), .SHIFT(1'b1)) u_hue (
                    .i_rem (r_hrem[j-1]),
                    .i_div (r_d6[j-1]),
                    .o_rem (n_hrem),
                    .o_bit (n_hbit)
                );
                assign n_sq = {r_sq[j-1][F-1:0], n_sbit};
                assign n_hq = {r_hq[j-1][F-2:0], n_hbit};

                always_ff @(posedge i_clk) begin
                    if (w_rdy[j+2]) begin
                        r_max[j]  <= r_max[j-1];
                        r_d6[j]   <= r_d6[j-1];
                        r_gray[j] <= r_gray[j-1];
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_rdy[j+2]) begin
                    r_srem[j] <= n_srem;
                    r_sq[j]   <= n_sq;
                    r_hrem[j] <= n_hrem;
                    r_hq[j]   <= n_hq;
                end
            end
        end
    endgenerate

    // ---------------- output: gray and black pixels give zero hue and sat -
    logic [F-1:0]     w_hue;
    logic [F:0]       w_sat;
    logic [PAY_W-1:0] w_payload;

    assign w_hue     = r_gray[F] ? '0 : r_hq[F];
    assign w_sat     = r_gray[F] ? '0 : r_sq[F];
    assign w_payload = {r_max[F], w_sat, w_hue};

    assign o_m_axis_tdata  = OUT_W'(w_payload);
    assign o_m_axis_tvalid = r_valid[NSTAGE-1];

endmodule

`default_nettype wire

@@ src/rhsv_checker.sv @@
// Port-level checks for rgb_to_hsv_converter_top, with its bind statement.
// Depends on rgb_to_hsv_converter_top's port names.
`default_nettype none

module rhsv_checker #(
    parameter int COMPONENT_BITS = 8,
    parameter int FRACTION_BITS  = 16
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic [((2*FRACTION_BITS+1+COMPONENT_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    input wire logic o_m_axis_tvalid,
    input wire logic i_m_axis_tready
);

    localparam int C = COMPONENT_BITS;
    localparam int F = FRACTION_BITS;

    logic [F-1:0] w_hue;
    logic [F:0]   w_sat;
    logic [C-1:0] w_bright;

    assign w_hue    = o_m_axis_tdata[F-1:0];
    assign w_sat    = o_m_axis_tdata[2*F:F];
    assign w_bright = o_m_axis_tdata[2*F+C:2*F+1];

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed or vanished");

    // black pixel: no saturation, no hue
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_bright == '0 |-> w_sat == '0 && w_hue == '0)
        else $error("black pixel with nonzero hue or saturation");

    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> w_sat <= {1'b1, {F{1'b0}}})
        else $error("saturation above one");

endmodule

bind rgb_to_hsv_converter_top rhsv_checker #(
    .COMPONENT_BITS (COMPONENT_BITS),
    .FRACTION_BITS  (FRACTION_BITS)
) u_rhsv_checker (.*);

`default_nettype wire

@@ bench/rhsv_stream_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the RGB to HSV converter: watches both stream channels,
// predicts each result from the accepted pixel and compares field by field.
// Depends on rhsv_pkg for the sector type.

module rhsv_stream_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel channel tdata: red [7:0], green [15:8], blue [23:16]
    input  logic [23:0] i_pix_tdata,
    input  logic        i_pix_tvalid,
    input  logic        i_pix_tready,
    // result channel tdata: hue_turn [15:0], saturation [32:16],
    // brightness [40:33], zero pad [47:41]
    input  logic [47:0] i_hsv_tdata,
    input  logic        i_hsv_tvalid,
    input  logic        i_hsv_tready,
    output int          o_mismatch_count,
    output int          o_pending
);

    localparam int FRAC_W = 16;

    typedef struct packed {
        logic [15:0] hue_turn;
        logic [16:0] saturation;
        logic [7:0]  brightness;
    } t_hsv;

    t_hsv hsv_expected_q[$];
    t_hsv want;
    int   bad;

    // Exact integer HSV: hue and saturation truncated to FRAC_W fraction bits.
    function automatic t_hsv hsv_of_pixel(input logic [7:0] r, g, b);
        logic [7:0]        hi;
        logic [7:0]        lo;
        longint unsigned   span;
        longint            numer;
        rhsv_pkg::t_sector sector;
        t_hsv              res;
        hi = r;
        lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        span = hi - lo;
        res.brightness = hi;
        res.saturation = (hi == 0) ? '0 : 17'((span << FRAC_W) / hi);
        // red wins ties, then green
        if (r == hi)      sector = rhsv_pkg::SECT_RED;
        else if (g == hi) sector = rhsv_pkg::SECT_GREEN;
        else              sector = rhsv_pkg::SECT_BLUE;
        if (span == 0) begin
            res.hue_turn = '0;          // gray: hue pinned to zero
        end else begin
            case (sector)
                rhsv_pkg::SECT_RED:
                    numer = longint'(g) - longint'(b);
                rhsv_pkg::SECT_GREEN:
                    numer = 2 * longint'(span) + longint'(b) - longint'(r);
                default:
                    numer = 4 * longint'(span) + longint'(r) - longint'(g);
            endcase
            if (numer < 0) numer += 6 * longint'(span);   // wrap one turn
            res.hue_turn = 16'((longint'(numer) << FRAC_W) / (6 * longint'(span)));
        end
        return res;
    endfunction

    initial begin
        o_mismatch_count = 0;
        o_pending        = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            bad = 0;
            if (i_hsv_tvalid && i_hsv_tready) begin
                if (hsv_expected_q.size() == 0) begin
                    $error("result transfer with no pixel pending, tdata %h", i_hsv_tdata);
                    bad = 1;
                end else begin
                    want = hsv_expected_q.pop_front();
                    if (i_hsv_tdata[15:0] !== want.hue_turn) begin
                        $error("hue_turn: expected %0d, actual %0d",
                               want.hue_turn, i_hsv_tdata[15:0]);
                        bad++;
                    end
                    if (i_hsv_tdata[32:16] !== want.saturation) begin
                        $error("saturation: expected %0d, actual %0d",
                               want.saturation, i_hsv_tdata[32:16]);
                        bad++;
                    end
                    if (i_hsv_tdata[40:33] !== want.brightness) begin
                        $error("brightness: expected %0d, actual %0d",
                               want.brightness, i_hsv_tdata[40:33]);
                        bad++;
                    end
                    if (i_hsv_tdata[47:41] !== 7'd0) begin
                        $error("pad: expected 0, actual %0d", i_hsv_tdata[47:41]);
                        bad++;
                    end
                end
            end
            if (i_pix_tvalid && i_pix_tready)
                hsv_expected_q.push_back(hsv_of_pixel(i_pix_tdata[7:0],
                                                      i_pix_tdata[15:8],
                                                      i_pix_tdata[23:16]));
            o_mismatch_count <= o_mismatch_count + bad;
            o_pending        <= hsv_expected_q.size();
        end
    end

endmodule

@@ bench/tb_rgb_to_hsv_converter_top.sv @@
`timescale 1ns / 1ps
// Top of the RGB to HSV converter bench: clock, reset, pixel stimulus,
// result back-pressure and verdict. Depends on rgb_to_hsv_converter_top
// and rhsv_stream_checker.

module tb_rgb_to_hsv_converter_top;

    localparam int COMP_W      = 8;
    localparam int FRAC_W      = 16;
    localparam int RANDOM_PIX  = 1050;
    localparam int CYCLE_LIMIT = 300000;
    localparam int IDLE_PCT    = 32;

    logic        i_clk;
    logic        i_rst_n;
    // pixel stream tdata: red [7:0], green [15:8], blue [23:16]
    logic [23:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    // result stream tdata: hue_turn [15:0], saturation [32:16],
    // brightness [40:33], zero pad [47:41]
    logic [47:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready;

    int          mismatch_count;
    int          hsv_pending;
    int          cycle_count;
    logic        sender_idles;     // sender leaves random gaps between pixels
    logic        receiver_stalls;  // receiver drops tready at random

    rgb_to_hsv_converter_top #(
        .COMPONENT_BITS(COMP_W),
        .FRACTION_BITS (FRAC_W)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready)
    );

    rhsv_stream_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pix_tdata     (s_tdata),
        .i_pix_tvalid    (s_tvalid),
        .i_pix_tready    (s_tready),
        .i_hsv_tdata     (m_tdata),
        .i_hsv_tvalid    (m_tvalid),
        .i_hsv_tready    (m_tready),
        .o_mismatch_count(mismatch_count),
        .o_pending       (hsv_pending)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Watchdog: a hung pipeline or lost result ends the run here.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side back-pressure, changed on the falling edge.
    always @(negedge i_clk) begin
        if (receiver_stalls)
            m_tready <= ($urandom_range(99, 0) >= IDLE_PCT);
        else
            m_tready <= 1'b1;
    end

    // One pixel transfer. Called and returns on a falling edge; valid is only
    // lowered when a gap is taken, so back-to-back pixels keep it high.
    task automatic send_pixel(input logic [7:0] r, g, b);
        while (sender_idles && $urandom_range(99, 0) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tdata  <= {b, g, r};
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    // Random pixel, biased toward grays, ties for the maximum, near-black values and the
    // corners of the cube; returned as {red, green, blue}.
    function automatic logic [23:0] random_pixel();
        logic [7:0] r, g, b;
        r = $urandom_range(255, 0);
        g = $urandom_range(255, 0);
        b = $urandom_range(255, 0);
        case ($urandom_range(9, 0))
            0: begin g = r; b = r; end                       // gray
            1: begin g = r; b = $urandom_range(r, 0); end   // red/green tie
            2: begin b = g; r = $urandom_range(g, 0); end   // green/blue tie
            3: begin b = r; g = $urandom_range(r, 0); end   // red/blue tie
            4: begin                                         // near black
                r = $urandom_range(3, 0);
                g = $urandom_range(3, 0);
                b = $urandom_range(3, 0);
            end
            5: begin                                         // cube corners
                r = $urandom_range(1, 0) ? 8'd255 : 8'd0;
                g = $urandom_range(1, 0) ? 8'd255 : 8'd0;
                b = $urandom_range(1, 0) ? 8'd255 : 8'd0;
            end
            default: ;
        endcase
        return {r, g, b};
    endfunction

    initial begin
        // directed pixels as 24'hRRGGBB
        logic [23:0] directed_px[$] = '{
            24'h000000,   // black: saturation zero, hue zero
            24'hFFFFFF,   // white: gray
            24'h808080,   // mid gray
            24'hFF0000,   // pure red
            24'h00FF00,   // pure green
            24'h0000FF,   // pure blue
            24'hFFFF00,   // red ties green, red wins
            24'h00FFFF,   // green ties blue, green wins
            24'hFF00FF,   // red ties blue, red wins
            24'hFF0001,   // red max, green below blue: hue wraps
            24'h010000,   // smallest non-black values
            24'h000100,
            24'h000001,
            24'h010100,
            24'hFEFFFD,   // tiny delta at the top
            24'h0A141E,
            24'hC86432,
            24'h32C864,
            24'h6432C8,
            24'hFFFE00,
            24'hAA55AA,   // alternating bit patterns
            24'h55AA55
        };
        logic [23:0] px;

        s_tvalid        = 1'b0;
        s_tdata         = '0;
        m_tready        = 1'b0;
        i_rst_n         = 1'b0;
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at full rate.
        foreach (directed_px[k])
            send_pixel(directed_px[k][23:16], directed_px[k][15:8], directed_px[k][7:0]);

        // Hold off until the pipeline has drained completely.
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (hsv_pending != 0) @(negedge i_clk);

        // Random part with gaps and stalls on both sides, one quiet stretch.
        sender_idles    <= 1'b1;
        receiver_stalls <= 1'b1;
        for (int n = 0; n < RANDOM_PIX; n++) begin
            if (n == 350) begin
                sender_idles    <= 1'b0;
                receiver_stalls <= 1'b0;
            end else if (n == 560) begin
                sender_idles    <= 1'b1;
                receiver_stalls <= 1'b1;
            end
            px = random_pixel();
            send_pixel(px[23:16], px[15:8], px[7:0]);
        end

        // Drain, then wait before the verdict.
        s_tvalid <= 1'b0;
        while (hsv_pending != 0) @(negedge i_clk);
        repeat (FRAC_W + 8) @(posedge i_clk);

        if (mismatch_count == 0 && hsv_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
